[src/bbmt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bbmt_pkg;

    localparam int GRID_SIZE_DEF = 128;
    localparam int COUNT_MAX_DEF = 255;

    // Widest group of flags that one encoder lane covers.
    localparam int LANE_MAX = 16;

    localparam int COORD_W = 7;
    localparam int EDGE_W  = 8;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TRY    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISSING  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic rd_en;
        logic adv;
        logic wr_en;
        logic wr_inc;
    } store_ctl_t;

endpackage

`default_nettype wire

[src/bounding_box_multiset_tracker_unit.sv]
// Channel   Dir  tdata                                         tuser
// s_        in   start_x, start_y, word_length, vertical      op
// m_        out  box_top, box_right, box_bottom, box_left     status
//
// A request reads its four counts at acceptance and updates them as it leaves the
// update stage, then passes the result stage, where its box is formed, into the output
// register that drives m_tvalid; one request per cycle while the output drains.
// The update stage holds the single write port of each count memory.
// Reset clears the per-entry nonzero flags, not the counts, so no clearing pass is needed.
// A stalled output holds its value and back pressure reaches s_tready.
`timescale 1ns / 1ps
`default_nettype none

module bounding_box_multiset_tracker_unit #(
    parameter int GRID_SIZE = bbmt_pkg::GRID_SIZE_DEF,
    parameter int COUNT_MAX = bbmt_pkg::COUNT_MAX_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // start_x, start_y, word_length, vertical, zero fill
    input  wire  [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // box_top, box_right, box_bottom, box_left, zero fill
    output logic [1:0]  m_tuser    // status
);

    localparam int EDGE_DEPTH = 2 * GRID_SIZE;
    localparam int G_W        = $clog2(GRID_SIZE);
    localparam int E_W        = $clog2(EDGE_DEPTH);
    localparam int CNT_W      = $clog2(COUNT_MAX + 1);
    localparam int CW         = bbmt_pkg::COORD_W;
    localparam int EW         = bbmt_pkg::EDGE_W;

    logic          accept;
    logic [CW-1:0] in_x;
    logic [CW-1:0] in_y;
    logic [CW-1:0] in_len;
    logic          in_vert;
    logic [EW-1:0] in_right;
    logic [EW-1:0] in_bottom;
    logic          in_ok;

    logic              s1_valid_reg;
    bbmt_pkg::op_t     s1_op_reg;
    logic [CW-1:0]     s1_x_reg;
    logic [CW-1:0]     s1_y_reg;
    logic [EW-1:0]     s1_right_reg;
    logic [EW-1:0]     s1_bottom_reg;
    logic              s1_ok_reg;
    logic              s1_adv;
    bbmt_pkg::status_t s1_status;
    logic              commit;
    logic              any_full;
    logic              any_empty;

    logic              s2_valid_reg;
    bbmt_pkg::op_t     s2_op_reg;
    logic [CW-1:0]     s2_x_reg;
    logic [CW-1:0]     s2_y_reg;
    logic [EW-1:0]     s2_right_reg;
    logic [EW-1:0]     s2_bottom_reg;
    bbmt_pkg::status_t s2_status_reg;
    logic              s2_adv;

    bbmt_pkg::store_ctl_t ctl;
    logic [CNT_W-1:0]     cnt_top;
    logic [CNT_W-1:0]     cnt_left;
    logic [CNT_W-1:0]     cnt_right;
    logic [CNT_W-1:0]     cnt_bottom;
    logic [G_W-1:0]       found_top;
    logic [G_W-1:0]       found_left;
    logic [E_W-1:0]       found_right;
    logic [E_W-1:0]       found_bottom;

    logic [CW-1:0] box_top;
    logic [EW-1:0] box_right;
    logic [EW-1:0] box_bottom;
    logic [CW-1:0] box_left;

    logic          m_tvalid_reg;
    logic [31:0]   m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    assign in_x    = s_tdata[6:0];
    assign in_y    = s_tdata[13:7];
    assign in_len  = s_tdata[20:14];
    assign in_vert = s_tdata[21];

    always_comb
    begin
        if (in_vert)
        begin
            in_right  = EW'(in_x) + EW'(1);
            in_bottom = EW'(in_y) + EW'(in_len);
        end
        else
        begin
            in_right  = EW'(in_x) + EW'(in_len);
            in_bottom = EW'(in_y) + EW'(1);
        end
        in_ok = (int'(in_x) < GRID_SIZE) && (int'(in_y) < GRID_SIZE) &&
                (int'(in_right) < EDGE_DEPTH) && (int'(in_bottom) < EDGE_DEPTH);
    end

    assign s2_adv   = s2_valid_reg && (!m_tvalid_reg || m_tready);
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        any_full  = !s1_ok_reg ||
                    (cnt_top >= CNT_W'(COUNT_MAX)) || (cnt_left >= CNT_W'(COUNT_MAX)) ||
                    (cnt_right >= CNT_W'(COUNT_MAX)) || (cnt_bottom >= CNT_W'(COUNT_MAX));
        any_empty = !s1_ok_reg ||
                    (cnt_top == '0) || (cnt_left == '0) ||
                    (cnt_right == '0) || (cnt_bottom == '0);
        s1_status = bbmt_pkg::ST_OK;
        case (s1_op_reg)
            bbmt_pkg::OP_ADD:
            begin
                if (any_full)
                begin
                    s1_status = bbmt_pkg::ST_OVERFLOW;
                end
            end
            bbmt_pkg::OP_REMOVE:
            begin
                if (any_empty)
                begin
                    s1_status = bbmt_pkg::ST_MISSING;
                end
            end
            default:
            begin
                s1_status = bbmt_pkg::ST_OK;
            end
        endcase
        commit = s1_adv && (s1_status == bbmt_pkg::ST_OK) &&
                 ((s1_op_reg == bbmt_pkg::OP_ADD) || (s1_op_reg == bbmt_pkg::OP_REMOVE));
    end

    always_comb
    begin
        ctl.rd_en  = accept;
        ctl.adv    = s1_adv;
        ctl.wr_en  = commit;
        ctl.wr_inc = (s1_op_reg == bbmt_pkg::OP_ADD);
    end

    bbmt_edge_store #(
        .DEPTH     (GRID_SIZE),
        .COUNT_MAX (COUNT_MAX),
        .FIND_HIGH (1'b0)
    ) u_top_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .rd_idx (G_W'(in_y)),
        .count  (cnt_top),
        .found  (found_top)
    );

    bbmt_edge_store #(
        .DEPTH     (GRID_SIZE),
        .COUNT_MAX (COUNT_MAX),
        .FIND_HIGH (1'b0)
    ) u_left_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .rd_idx (G_W'(in_x)),
        .count  (cnt_left),
        .found  (found_left)
    );

    bbmt_edge_store #(
        .DEPTH     (EDGE_DEPTH),
        .COUNT_MAX (COUNT_MAX),
        .FIND_HIGH (1'b1)
    ) u_right_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .rd_idx (E_W'(in_right)),
        .count  (cnt_right),
        .found  (found_right)
    );

    bbmt_edge_store #(
        .DEPTH     (EDGE_DEPTH),
        .COUNT_MAX (COUNT_MAX),
        .FIND_HIGH (1'b1)
    ) u_bottom_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .rd_idx (E_W'(in_bottom)),
        .count  (cnt_bottom),
        .found  (found_bottom)
    );

    always_comb
    begin
        box_top    = CW'(found_top);
        box_right  = EW'(found_right);
        box_bottom = EW'(found_bottom);
        box_left   = CW'(found_left);
        if (s2_op_reg == bbmt_pkg::OP_TRY)
        begin
            if (s2_y_reg < box_top)
            begin
                box_top = s2_y_reg;
            end
            if (s2_right_reg > box_right)
            begin
                box_right = s2_right_reg;
            end
            if (s2_bottom_reg > box_bottom)
            begin
                box_bottom = s2_bottom_reg;
            end
            if (s2_x_reg < box_left)
            begin
                box_left = s2_x_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (!s2_valid_reg || s2_adv)
            begin
                s2_valid_reg <= s1_adv;
            end
            if (!m_tvalid_reg || m_tready)
            begin
                m_tvalid_reg <= s2_adv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= bbmt_pkg::op_t'(s_tuser);
            s1_x_reg      <= in_x;
            s1_y_reg      <= in_y;
            s1_right_reg  <= in_right;
            s1_bottom_reg <= in_bottom;
            s1_ok_reg     <= in_ok;
        end
        if (s1_adv)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_right_reg  <= s1_right_reg;
            s2_bottom_reg <= s1_bottom_reg;
            s2_status_reg <= s1_status;
        end
        if (s2_adv)
        begin
            m_tdata_reg <= {2'b00, box_left, box_bottom, box_right, box_top};
            m_tuser_reg <= s2_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // A new request may only enter the update stage as the one there leaves.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> s1_adv)
        else $error("request accepted over a stalled update stage");

    // A rejected add or remove must leave the counts untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_status != bbmt_pkg::ST_OK)) |-> !commit)
        else $error("count written for a rejected request");

    // A result waiting for the output register keeps its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_adv) |=> (s2_valid_reg && $stable(s2_status_reg)))
        else $error("pending result lost or changed");
`endif

endmodule

`default_nettype wire

[src/bbmt_edge_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module bbmt_edge_store #(
    parameter int DEPTH = bbmt_pkg::GRID_SIZE_DEF,
    parameter int COUNT_MAX = bbmt_pkg::COUNT_MAX_DEF,
    parameter bit FIND_HIGH = 1'b0,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(COUNT_MAX + 1)
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  bbmt_pkg::store_ctl_t     ctl,
    input  wire [IDX_W-1:0]          rd_idx,
    output logic [CNT_W-1:0]         count,
    output logic [IDX_W-1:0]         found
);

    localparam int LANE  = (DEPTH < bbmt_pkg::LANE_MAX) ? DEPTH : bbmt_pkg::LANE_MAX;
    localparam int NLANE = (DEPTH + LANE - 1) / LANE;
    localparam int LW    = $clog2(LANE);
    localparam int PAD   = NLANE * LANE;

    logic [CNT_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0] rdata_reg;
    logic [CNT_W-1:0] fwd_data_reg;
    logic             fwd_hit_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] new_cnt;

    logic [DEPTH-1:0] live_reg;
    logic [DEPTH-1:0] live_next;
    logic [PAD-1:0]   padded;
    logic [NLANE-1:0] any_reg;
    logic [NLANE-1:0] any_next;
    logic [LW-1:0]    sub_reg  [NLANE];
    logic [LW-1:0]    sub_next [NLANE];

    // An entry whose flag is clear reads as zero, so the array needs no clearing.
    always_comb
    begin
        if (!live_reg[idx_reg])
        begin
            count = '0;
        end
        else if (fwd_hit_reg)
        begin
            count = fwd_data_reg;
        end
        else
        begin
            count = rdata_reg;
        end
        new_cnt = ctl.wr_inc ? count + CNT_W'(1) : count - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[idx_reg] <= new_cnt;
        end
        if (ctl.rd_en)
        begin
            rdata_reg    <= mem[rd_idx];
            idx_reg      <= rd_idx;
            fwd_data_reg <= new_cnt;
        end
    end

    always_comb
    begin
        live_next = live_reg;
        if (ctl.wr_en)
        begin
            live_next[idx_reg] = (new_cnt != '0);
        end
    end

    always_comb
    begin
        int k;
        padded = PAD'(live_next);
        for (int l = 0; l < NLANE; l++)
        begin
            any_next[l] = |padded[l*LANE +: LANE];
            sub_next[l] = '0;
            for (int j = 0; j < LANE; j++)
            begin
                k = FIND_HIGH ? j : LANE - 1 - j;
                if (padded[l*LANE + k])
                begin
                    sub_next[l] = LW'(k);
                end
            end
        end
    end

    always_comb
    begin
        int k;
        found = '0;
        for (int l = 0; l < NLANE; l++)
        begin
            k = FIND_HIGH ? l : NLANE - 1 - l;
            if (any_reg[k])
            begin
                found = IDX_W'(k * LANE + int'(sub_reg[k]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg    <= '0;
            any_reg     <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
            if (ctl.adv)
            begin
                any_reg <= any_next;
            end
            if (ctl.rd_en)
            begin
                fwd_hit_reg <= ctl.wr_en && (rd_idx == idx_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            sub_reg <= sub_next;
        end
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] OP_UNDEF = 2'd3;
    localparam int EDGE_DEPTH = 2 * bbmt_pkg::GRID_SIZE_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [6:0] x;
        logic [6:0] y;
        logic [6:0] len;
        logic       vert;
    } word_t;

    typedef struct packed {
        logic [6:0] top;
        logic [7:0] right;
        logic [7:0] bottom;
        logic [6:0] left;
        logic [1:0] status;
    } box_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    int top_cnt[bbmt_pkg::GRID_SIZE_DEF];
    int left_cnt[bbmt_pkg::GRID_SIZE_DEF];
    int right_cnt[EDGE_DEPTH];
    int bottom_cnt[EDGE_DEPTH];

    box_t  pending_boxes[$];
    word_t placed_words[$];
    int    idle_pct = 0;
    int    stall_pct = 0;
    int    mismatch_count = 0;
    int    cycle_count = 0;

    bounding_box_multiset_tracker_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Applies one request to the edge counts and returns the box it reports.
    function automatic box_t track_box(input logic [1:0] op, input word_t w);
        logic [7:0] r_edge;
        logic [7:0] b_edge;
        logic       any_full;
        logic       any_empty;
        box_t       box;
        r_edge = w.vert ? {1'b0, w.x} + 8'd1 : {1'b0, w.x} + {1'b0, w.len};
        b_edge = w.vert ? {1'b0, w.y} + {1'b0, w.len} : {1'b0, w.y} + 8'd1;
        any_full = top_cnt[w.y] >= bbmt_pkg::COUNT_MAX_DEF
                || left_cnt[w.x] >= bbmt_pkg::COUNT_MAX_DEF
                || right_cnt[r_edge] >= bbmt_pkg::COUNT_MAX_DEF
                || bottom_cnt[b_edge] >= bbmt_pkg::COUNT_MAX_DEF;
        any_empty = top_cnt[w.y] == 0 || left_cnt[w.x] == 0
                 || right_cnt[r_edge] == 0 || bottom_cnt[b_edge] == 0;
        box = '0;
        box.status = bbmt_pkg::ST_OK;
        if (op == bbmt_pkg::OP_ADD)
        begin
            if (any_full)
            begin
                box.status = bbmt_pkg::ST_OVERFLOW;
            end
            else
            begin
                top_cnt[w.y]++;
                left_cnt[w.x]++;
                right_cnt[r_edge]++;
                bottom_cnt[b_edge]++;
            end
        end
        else if (op == bbmt_pkg::OP_REMOVE)
        begin
            if (any_empty)
            begin
                box.status = bbmt_pkg::ST_MISSING;
            end
            else
            begin
                top_cnt[w.y]--;
                left_cnt[w.x]--;
                right_cnt[r_edge]--;
                bottom_cnt[b_edge]--;
            end
        end
        for (int i = bbmt_pkg::GRID_SIZE_DEF - 1; i >= 0; i--)
        begin
            if (top_cnt[i] != 0) box.top = 7'(i);
            if (left_cnt[i] != 0) box.left = 7'(i);
        end
        for (int i = 0; i < EDGE_DEPTH; i++)
        begin
            if (right_cnt[i] != 0) box.right = 8'(i);
            if (bottom_cnt[i] != 0) box.bottom = 8'(i);
        end
        if (op == bbmt_pkg::OP_TRY)
        begin
            if (w.y < box.top) box.top = w.y;
            if (w.x < box.left) box.left = w.x;
            if (r_edge > box.right) box.right = r_edge;
            if (b_edge > box.bottom) box.bottom = b_edge;
        end
        return box;
    endfunction

    function automatic word_t make_word(input logic [6:0] x, input logic [6:0] y,
                                        input logic [6:0] len, input logic vert);
        word_t w;
        w.x = x;
        w.y = y;
        w.len = len;
        w.vert = vert;
        return w;
    endfunction

    // Clustered words share edges often, so counts climb and ties appear.
    function automatic word_t random_word();
        word_t w;
        if ($urandom_range(1) == 0)
        begin
            w = make_word(7'($urandom_range(127)), 7'($urandom_range(127)),
                          7'($urandom_range(127)), 1'($urandom_range(1)));
        end
        else
        begin
            w = make_word(7'($urandom_range(47, 40)), 7'($urandom_range(47, 40)),
                          7'($urandom_range(7)), 1'($urandom_range(1)));
        end
        return w;
    endfunction

    task automatic send_word(input logic [1:0] op, input word_t w);
        box_t box;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, w.vert, w.len, w.y, w.x};
        s_tuser <= op;
        box = track_box(op, w);
        pending_boxes.push_back(box);
        if (op == bbmt_pkg::OP_ADD && box.status == bbmt_pkg::ST_OK) placed_words.push_back(w);
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic set_pace(input int idle, input int stall);
        idle_pct = idle;
        stall_pct = stall;
    endtask

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        box_t got;
        box_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.top = m_tdata[6:0];
            got.right = m_tdata[14:7];
            got.bottom = m_tdata[22:15];
            got.left = m_tdata[29:23];
            got.status = m_tuser;
            if (pending_boxes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected box: top %0d right %0d bottom %0d left %0d status %0d",
                             got.top, got.right, got.bottom, got.left, got.status);
            end
            else
            begin
                want = pending_boxes.pop_front();
                if (got.top != want.top || got.right != want.right
                    || got.bottom != want.bottom || got.left != want.left
                    || got.status != want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("box mismatch: expected %0d/%0d/%0d/%0d/%0d, %s",
                                 want.top, want.right, want.bottom, want.left, want.status,
                                 $sformatf("got %0d/%0d/%0d/%0d/%0d",
                                           got.top, got.right, got.bottom, got.left,
                                           got.status));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic test_empty_box();
        send_word(bbmt_pkg::OP_TRY, make_word(0, 0, 0, 0));
        send_word(OP_UNDEF, make_word(127, 127, 127, 1));
        send_word(bbmt_pkg::OP_REMOVE, make_word(3, 4, 5, 0));
    endtask

    task automatic test_extremes();
        send_word(bbmt_pkg::OP_ADD, make_word(127, 127, 127, 0));
        send_word(bbmt_pkg::OP_ADD, make_word(127, 127, 127, 1));
        send_word(bbmt_pkg::OP_ADD, make_word(0, 0, 0, 0));
        send_word(bbmt_pkg::OP_TRY, make_word(0, 0, 127, 1));
        send_word(bbmt_pkg::OP_TRY, make_word(127, 127, 127, 0));
        send_word(OP_UNDEF, make_word(64, 21, 85, 0));
        // Top, left and bottom exist here but the right edge does not.
        send_word(bbmt_pkg::OP_REMOVE, make_word(0, 0, 1, 0));
        send_word(bbmt_pkg::OP_REMOVE, make_word(127, 127, 127, 0));
        send_word(bbmt_pkg::OP_REMOVE, make_word(127, 127, 127, 1));
        send_word(bbmt_pkg::OP_REMOVE, make_word(0, 0, 0, 0));
        send_word(bbmt_pkg::OP_REMOVE, make_word(0, 0, 0, 0));
        send_word(OP_UNDEF, make_word(0, 0, 0, 0));
    endtask

    task automatic test_count_overflow();
        word_t w;
        w = make_word(5, 9, 3, 0);
        repeat (bbmt_pkg::COUNT_MAX_DEF) send_word(bbmt_pkg::OP_ADD, w);
        send_word(bbmt_pkg::OP_ADD, w);
        // Shares only the top edge, which is already full.
        send_word(bbmt_pkg::OP_ADD, make_word(60, 9, 4, 1));
        send_word(bbmt_pkg::OP_TRY, make_word(2, 20, 9, 1));
        repeat (bbmt_pkg::COUNT_MAX_DEF) send_word(bbmt_pkg::OP_REMOVE, w);
        send_word(bbmt_pkg::OP_REMOVE, w);
        placed_words.delete();
    endtask

    task automatic test_random_words(input int count);
        int    pick;
        int    idx;
        word_t w;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 35 || (pick < 70 && placed_words.size() == 0))
            begin
                send_word(bbmt_pkg::OP_ADD, random_word());
            end
            else if (pick < 70)
            begin
                idx = $urandom_range(placed_words.size() - 1);
                w = placed_words[idx];
                placed_words.delete(idx);
                send_word(bbmt_pkg::OP_REMOVE, w);
            end
            else if (pick < 85)
            begin
                send_word(bbmt_pkg::OP_TRY, random_word());
            end
            else if (pick < 93)
            begin
                send_word(bbmt_pkg::OP_REMOVE, random_word());
            end
            else
            begin
                send_word(OP_UNDEF, random_word());
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_pace(0, 0);
        test_empty_box();
        test_extremes();
        test_count_overflow();
        set_pace(0, 0);
        test_random_words(195);
        set_pace(71, 0);
        test_random_words(195);
        set_pace(0, 71);
        test_random_words(195);
        set_pace(24, 24);
        test_random_words(195);
        s_tvalid <= 1'b0;
        set_pace(0, 0);
        while (pending_boxes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_boxes.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
